FILE: hdl/iac_pkg.sv
// ---------------------------------------------------------------------------
// iac_pkg
// Shared constants for the motion activity classifier: register indexes,
// coefficient reset values and normalization constants.
// ---------------------------------------------------------------------------
package iac_pkg;

	localparam int SFB_DEFAULT = 8;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_HIGHPASS  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOWPASS   = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIT_RISE = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIT_FALL = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NOD_RISE  = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NOD_FALL  = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LOOK_RISE = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_LOOK_FALL = 4'd7;

	localparam logic [15:0] RST_HIGHPASS  = 16'd63537;
	localparam logic [15:0] RST_LOWPASS   = 16'd8235;
	localparam logic [15:0] RST_GAIT_RISE = 16'd328;
	localparam logic [15:0] RST_GAIT_FALL = 16'd218;
	localparam logic [15:0] RST_NOD_RISE  = 16'd3277;
	localparam logic [15:0] RST_NOD_FALL  = 16'd328;
	localparam logic [15:0] RST_LOOK_RISE = 16'd2185;
	localparam logic [15:0] RST_LOOK_FALL = 16'd437;

	localparam int ONE_Q15 = 32768;

	// gait: 32768 * 100 / 16384 = 200 per state LSB (before the fraction shift)
	localparam int GAIT_SCALE = 200;

	// nod: q = round(env * 1024 / (75 * 2^F)); look: q = round(env * 64 / (25 * 2^F))
	localparam int NOD_SHIFT  = 11;
	localparam int LOOK_SHIFT = 7;
	localparam logic [6:0] NOD_DIV  = 7'd75;
	localparam logic [6:0] LOOK_DIV = 7'd25;
	localparam logic [6:0] SUP_DIV  = 7'd7;

	// reciprocals: floor(x / d) = (x * ceil(2^s / d)) >> s, exact below d * 32770
	localparam int NOD_RECIP  = 7158279;
	localparam int NOD_RSH    = 29;
	localparam int LOOK_RECIP = 5368710;
	localparam int LOOK_RSH   = 27;
	localparam int SUP_RECIP  = 4793491;
	localparam int SUP_RSH    = 25;

	// suppression: (10 * gait - 0.3 * 10) / 7, rounded
	localparam int SUP_SCALE = 10;
	localparam int SUP_START = 98304;
	localparam int SUP_ROUND = 3;

	// quotient saturates at 1.0 once the dividend reaches divisor * 32769
	localparam int SAT_MULT = 32769;

endpackage

FILE: hdl/imu_activity_classifier.sv
// ---------------------------------------------------------------------------
// imu_activity_classifier
// Band-pass envelope followers on two acceleration axes and envelope followers on two rate axes,
// normalized into gait, nod, look, suppression, social and total levels.
// ---------------------------------------------------------------------------
// An input transaction is taken only when idle and is processed by thirteen
// passes through the shared multiplier (operand load, multiply, writeback
// each) and two 16-step serial square roots; the last step stalls while
// the previous result waits for out_ready.
// Reset: asynchronous, clears all filter state and loads default coefficients.
module imu_activity_classifier import iac_pkg::*; #(
	parameter int STATE_FRACTION_BITS = SFB_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [15:0]    accel_lateral,
	input  logic signed [15:0]    accel_vertical,
	input  logic signed [15:0]    pitch_rate,
	input  logic signed [15:0]    yaw_rate,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [15:0]           gait_level,
	output logic [15:0]           nod_level,
	output logic [15:0]           look_level,
	output logic [15:0]           walk_suppress,
	output logic [15:0]           social_level,
	output logic [15:0]           total_activity
);

	localparam int F    = STATE_FRACTION_BITS;
	localparam int HPW  = 18 + F;
	localparam int ENVW = 17 + F;
	localparam int RW   = 16 + F;
	localparam int AW   = 19 + F;
	localparam int BW   = 24;
	localparam int PW   = AW + BW;
	localparam int XW   = 28 + F;

	localparam logic signed [AW-1:0] ENV_MAX = $signed(AW'({ENVW{1'b1}}));
	localparam logic signed [PW-1:0] HP_HI   = $signed(PW'({(HPW-1){1'b1}}));
	localparam logic signed [PW-1:0] HP_LO   = -HP_HI - PW'(1);
	localparam logic signed [PW-1:0] RND16   = PW'(32768);
	localparam logic signed [PW-1:0] RND15   = PW'(16384);
	localparam logic signed [PW-1:0] RNDF    = PW'(2 ** (F - 1));
	localparam logic signed [PW-1:0] ONE_P   = PW'(ONE_Q15);

	typedef enum logic [3:0] {
		ST_IDLE, ST_HP, ST_BP, ST_ENV, ST_RATE, ST_GAIT, ST_NOD_DIV, ST_NOD_SQRT,
		ST_LOOK_DIV, ST_LOOK_SQRT, ST_SUP_DIV, ST_SOC, ST_DONE
	} state_t;

	typedef enum logic [1:0] {PH_LOAD, PH_RUN, PH_WB} phase_t;

	state_t state_q;
	phase_t phase_q;
	logic   sel_q;

	logic [15:0] hp_coeff_q, lp_coeff_q, gr_coeff_q, gf_coeff_q;
	logic [15:0] nr_coeff_q, nf_coeff_q, lr_coeff_q, lf_coeff_q;

	logic signed [HPW-1:0]  hp_q   [2];
	logic signed [15:0]     last_q [2];
	logic signed [HPW-1:0]  bp_q   [2];
	logic        [ENVW-1:0] env_q  [2];
	logic        [RW-1:0]   renv_q [2];
	logic signed [15:0]     acc_q  [2];
	logic signed [15:0]     rate_q [2];

	logic signed [AW-1:0] opa_q;
	logic signed [BW-1:0] opb_q;
	logic signed [PW-1:0] p_q;

	logic [15:0] gl_q, nodq_q, lookq_q, nl_q, ll_q, sup_q, soc_q, tot_q;

	logic [31:0] sq_v_q, sq_r_q;
	logic [3:0]  sq_k_q;

	logic        out_valid_q;
	logic [15:0] gait_o_q, nod_o_q, look_o_q, sup_o_q, soc_o_q, tot_o_q;

	// ratio set-up: dividend clipped at the saturation point, reciprocal by step
	logic [XW-1:0]        dv_y, dv_lim, dv_x, g10;
	logic [6:0]           dv_d;
	logic signed [BW-1:0] dv_m;
	logic [15:0]          sq_in;
	logic [31:0]          sq_bit, sq_trial;
	logic [16:0]          sq_res;

	always_comb begin
		g10 = XW'(gl_q) * XW'(SUP_SCALE);
		case (state_q)
			ST_NOD_DIV: begin
				dv_y = ((XW'(renv_q[0]) << NOD_SHIFT) + (XW'(NOD_DIV) << F)) >> (F + 1);
				dv_d = NOD_DIV;
				dv_m = BW'(NOD_RECIP);
			end
			ST_LOOK_DIV: begin
				dv_y = ((XW'(renv_q[1]) << LOOK_SHIFT) + (XW'(LOOK_DIV) << F)) >> (F + 1);
				dv_d = LOOK_DIV;
				dv_m = BW'(LOOK_RECIP);
			end
			ST_SUP_DIV: begin
				dv_y = (g10 > XW'(SUP_START)) ? (g10 - XW'(SUP_START) + XW'(SUP_ROUND)) : '0;
				dv_d = SUP_DIV;
				dv_m = BW'(SUP_RECIP);
			end
			default: begin
				dv_y = '0;
				dv_d = SUP_DIV;
				dv_m = BW'(SUP_RECIP);
			end
		endcase
		dv_lim   = XW'(dv_d) * XW'(SAT_MULT);
		dv_x     = (dv_y > dv_lim) ? dv_lim : dv_y;
		sq_in    = (state_q == ST_LOOK_SQRT) ? lookq_q : nodq_q;
		sq_bit   = 32'd1 << {sq_k_q, 1'b0};
		sq_trial = sq_r_q + sq_bit;
		sq_res   = 17'(sq_r_q[15:0]) + 17'(sq_v_q > sq_r_q);
	end

	// operand selection
	logic signed [AW-1:0] hp_x, acc_x, last_x, bp_x, bp_abs, mag, env_x, renv_x, rmag;
	logic signed [16:0]   r17, rate_abs;
	logic [16:0]          soc_sum, soc_cl;
	logic signed [AW-1:0] opa_d;
	logic signed [BW-1:0] opb_d;

	always_comb begin
		hp_x     = AW'(hp_q[sel_q]);
		acc_x    = AW'(acc_q[sel_q]);
		last_x   = AW'(last_q[sel_q]);
		bp_x     = AW'(bp_q[sel_q]);
		bp_abs   = (bp_x < 0) ? -bp_x : bp_x;
		mag      = (bp_abs > ENV_MAX) ? ENV_MAX : bp_abs;
		env_x    = $signed(AW'(env_q[sel_q]));
		renv_x   = $signed(AW'(renv_q[sel_q]));
		r17      = 17'(rate_q[sel_q]);
		rate_abs = (r17 < 0) ? -r17 : r17;
		rmag     = $signed(AW'(rate_abs)) <<< F;
		soc_sum  = 17'(nl_q) + 17'(ll_q);
		soc_cl   = (soc_sum > 17'(ONE_Q15)) ? 17'(ONE_Q15) : soc_sum;
		opa_d    = '0;
		opb_d    = '0;
		case (state_q)
			ST_HP: begin
				opa_d = hp_x + ((acc_x - last_x) <<< F);
				opb_d = BW'(hp_coeff_q);
			end
			ST_BP: begin
				opa_d = hp_x - bp_x;
				opb_d = BW'(lp_coeff_q);
			end
			ST_ENV: begin
				opa_d = mag - env_x;
				opb_d = (mag > env_x) ? BW'(gr_coeff_q) : BW'(gf_coeff_q);
			end
			ST_RATE: begin
				opa_d = rmag - renv_x;
				if (sel_q)
					opb_d = (rmag > renv_x) ? BW'(lr_coeff_q) : BW'(lf_coeff_q);
				else
					opb_d = (rmag > renv_x) ? BW'(nr_coeff_q) : BW'(nf_coeff_q);
			end
			ST_GAIT: begin
				opa_d = (env_q[0] < env_q[1]) ? $signed(AW'(env_q[0])) :
					$signed(AW'(env_q[1]));
				opb_d = BW'(GAIT_SCALE);
			end
			ST_NOD_DIV, ST_LOOK_DIV, ST_SUP_DIV: begin
				opa_d = $signed(AW'(dv_x));
				opb_d = dv_m;
			end
			ST_SOC: begin
				opa_d = $signed(AW'(soc_cl));
				opb_d = $signed(BW'(ONE_Q15) - BW'(sup_q));
			end
			default: begin
				opa_d = '0;
				opb_d = '0;
			end
		endcase
	end

	// writeback arithmetic
	logic signed [PW-1:0] rq, bp_sum, env_sum, renv_sum, g_sh, s_sh, q_sh;
	logic signed [HPW-1:0] hp_new, bp_new;
	logic [15:0] gl_d, soc_d, tot_d, q_d;
	logic [16:0] tot_sum;

	always_comb begin
		rq       = (p_q + RND16) >>> 16;
		hp_new   = (rq > HP_HI) ? HPW'(HP_HI) : ((rq < HP_LO) ? HPW'(HP_LO) : HPW'(rq));
		bp_sum   = PW'(bp_q[sel_q]) + rq;
		bp_new   = (bp_sum > HP_HI) ? HPW'(HP_HI) :
			((bp_sum < HP_LO) ? HPW'(HP_LO) : HPW'(bp_sum));
		env_sum  = $signed(PW'(env_q[sel_q])) + rq;
		renv_sum = $signed(PW'(renv_q[sel_q])) + rq;
		g_sh     = (p_q + RNDF) >>> F;
		gl_d     = (g_sh > ONE_P) ? 16'(ONE_Q15) : g_sh[15:0];
		s_sh     = (p_q + RND15) >>> 15;
		soc_d    = s_sh[15:0];
		tot_sum  = 17'(soc_d) + 17'(gl_q);
		tot_d    = (tot_sum > 17'(ONE_Q15)) ? 16'(ONE_Q15) : tot_sum[15:0];
		case (state_q)
			ST_NOD_DIV:  q_sh = p_q >>> NOD_RSH;
			ST_LOOK_DIV: q_sh = p_q >>> LOOK_RSH;
			default:     q_sh = p_q >>> SUP_RSH;
		endcase
		q_d      = (q_sh > ONE_P) ? 16'(ONE_Q15) : q_sh[15:0];
	end

	assign in_ready       = (state_q == ST_IDLE);
	assign out_valid      = out_valid_q;
	assign gait_level     = gait_o_q;
	assign nod_level      = nod_o_q;
	assign look_level     = look_o_q;
	assign walk_suppress  = sup_o_q;
	assign social_level   = soc_o_q;
	assign total_activity = tot_o_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_LOAD;
			sel_q       <= 1'b0;
			out_valid_q <= 1'b0;
			hp_coeff_q  <= RST_HIGHPASS;
			lp_coeff_q  <= RST_LOWPASS;
			gr_coeff_q  <= RST_GAIT_RISE;
			gf_coeff_q  <= RST_GAIT_FALL;
			nr_coeff_q  <= RST_NOD_RISE;
			nf_coeff_q  <= RST_NOD_FALL;
			lr_coeff_q  <= RST_LOOK_RISE;
			lf_coeff_q  <= RST_LOOK_FALL;
			for (int i = 0; i < 2; i++) begin
				hp_q[i]   <= '0;
				last_q[i] <= '0;
				bp_q[i]   <= '0;
				env_q[i]  <= '0;
				renv_q[i] <= '0;
			end
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_HIGHPASS:  hp_coeff_q <= cfg_data;
					REG_LOWPASS:   lp_coeff_q <= cfg_data;
					REG_GAIT_RISE: gr_coeff_q <= cfg_data;
					REG_GAIT_FALL: gf_coeff_q <= cfg_data;
					REG_NOD_RISE:  nr_coeff_q <= cfg_data;
					REG_NOD_FALL:  nf_coeff_q <= cfg_data;
					REG_LOOK_RISE: lr_coeff_q <= cfg_data;
					REG_LOOK_FALL: lf_coeff_q <= cfg_data;
					default: ;
				endcase
			end

			// in the final step the result register is reloaded instead
			if (out_valid_q && out_ready && state_q != ST_DONE)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						acc_q[0]  <= accel_lateral;
						acc_q[1]  <= accel_vertical;
						rate_q[0] <= pitch_rate;
						rate_q[1] <= yaw_rate;
						sel_q     <= 1'b0;
						phase_q   <= PH_LOAD;
						state_q   <= ST_HP;
					end
				end
				ST_HP, ST_BP, ST_ENV, ST_RATE, ST_GAIT, ST_NOD_DIV, ST_LOOK_DIV,
				ST_SUP_DIV, ST_SOC: begin
					case (phase_q)
						PH_LOAD: begin
							opa_q   <= opa_d;
							opb_q   <= opb_d;
							phase_q <= PH_RUN;
						end
						PH_RUN: begin
							p_q     <= PW'(opa_q) * PW'(opb_q);
							phase_q <= PH_WB;
						end
						default: begin
							phase_q <= PH_LOAD;
							case (state_q)
								ST_HP: begin
									hp_q[sel_q]   <= hp_new;
									last_q[sel_q] <= acc_q[sel_q];
									state_q       <= ST_BP;
								end
								ST_BP: begin
									bp_q[sel_q] <= bp_new;
									state_q     <= ST_ENV;
								end
								ST_ENV: begin
									env_q[sel_q] <= env_sum[ENVW-1:0];
									sel_q        <= ~sel_q;
									state_q      <= sel_q ? ST_RATE : ST_HP;
								end
								ST_RATE: begin
									renv_q[sel_q] <= renv_sum[RW-1:0];
									sel_q         <= ~sel_q;
									state_q       <= sel_q ? ST_GAIT : ST_RATE;
								end
								ST_GAIT: begin
									gl_q    <= gl_d;
									state_q <= ST_NOD_DIV;
								end
								ST_NOD_DIV: begin
									nodq_q  <= q_d;
									state_q <= ST_NOD_SQRT;
								end
								ST_LOOK_DIV: begin
									lookq_q <= q_d;
									state_q <= ST_LOOK_SQRT;
								end
								ST_SUP_DIV: begin
									sup_q   <= q_d;
									state_q <= ST_SOC;
								end
								default: begin
									soc_q   <= soc_d;
									tot_q   <= tot_d;
									state_q <= ST_DONE;
								end
							endcase
						end
					endcase
				end
				ST_NOD_SQRT, ST_LOOK_SQRT: begin
					case (phase_q)
						PH_LOAD: begin
							sq_v_q  <= {1'b0, sq_in, 15'd0};
							sq_r_q  <= '0;
							sq_k_q  <= 4'd15;
							phase_q <= PH_RUN;
						end
						PH_RUN: begin
							if (sq_v_q >= sq_trial) begin
								sq_v_q <= sq_v_q - sq_trial;
								sq_r_q <= (sq_r_q >> 1) + sq_bit;
							end else begin
								sq_r_q <= sq_r_q >> 1;
							end
							sq_k_q <= sq_k_q - 4'd1;
							if (sq_k_q == 4'd0)
								phase_q <= PH_WB;
						end
						default: begin
							phase_q <= PH_LOAD;
							if (state_q == ST_NOD_SQRT) begin
								nl_q    <= sq_res[15:0];
								state_q <= ST_LOOK_DIV;
							end else begin
								ll_q    <= sq_res[15:0];
								state_q <= ST_SUP_DIV;
							end
						end
					endcase
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						gait_o_q    <= gl_q;
						nod_o_q     <= nl_q;
						look_o_q    <= ll_q;
						sup_o_q     <= sup_q;
						soc_o_q     <= soc_q;
						tot_o_q     <= tot_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
